>>> sv/mts_pkg.sv
// shared types, widths and codes of the monthly trend slope block
package mts_pkg;

   localparam int MONTHS      = 12;
   localparam int MAX_SAMPLES = 1024;
   localparam int CNT_W       = 11;
   localparam int SX_W        = 23;
   localparam int SY_W        = 27;
   localparam int SXY_W       = 39;
   localparam int SXX_W       = 35;
   localparam int WIDE_W      = 52;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = 2;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FEW  = 2'd1;
   localparam logic [1:0] STAT_ZERO = 2'd2;
   localparam logic [1:0] STAT_DROP = 2'd3;

   localparam logic [1:0] REG_START_YEAR  = 2'd0;
   localparam logic [1:0] REG_END_YEAR    = 2'd1;
   localparam logic [1:0] REG_MIN_SAMPLES = 2'd2;

   typedef struct packed {
      logic [3:0]         month;
      logic [11:0]        x;
      logic signed [15:0] y;
      logic signed [27:0] xy;
      logic [23:0]        xx;
      logic               take;
      logic               last;
   } sample_type;

   typedef struct packed {
      logic [3:0]         month_index;
      logic signed [31:0] slope;
      logic [1:0]         status;
      logic               last_of_run;
   } result_type;

endpackage

>>> sv/mts_if.sv
// channel interfaces for records and slope results
interface mts_req_if;
   import mts_pkg::*;
   logic               valid;
   logic               ready;
   logic [11:0]        year;
   logic [3:0]         month;
   logic signed [15:0] anomaly;
   logic               is_missing;
   logic               last_record;
   modport source (output valid, year, month, anomaly, is_missing, last_record, input ready);
   modport sink (input valid, year, month, anomaly, is_missing, last_record, output ready);
endinterface

interface mts_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         month_index;
   logic signed [31:0] slope;
   logic [1:0]         status;
   logic               last_of_run;
   modport source (output valid, month_index, slope, status, last_of_run, input ready);
   modport sink (input valid, month_index, slope, status, last_of_run, output ready);
endinterface

>>> sv/mts_front.sv
// front end: classifies records against the year window and forms products
module mts_front
   import mts_pkg::*;
(
   input  logic [11:0]        year,
   input  logic [3:0]         month,
   input  logic signed [15:0] anomaly,
   input  logic               is_missing,
   input  logic               last_record,
   input  logic [11:0]        start_year,
   input  logic [11:0]        end_year,
   output sample_type         sample
);

   always_comb begin
      sample.month = month;
      sample.x     = year;
      sample.y     = anomaly;
      sample.xy    = 28'($signed({1'b0, year})) * 28'(anomaly);
      sample.xx    = 24'(year) * 24'(year);
      sample.take  = !is_missing && (month < 4'(MONTHS)) &&
                     (year >= start_year) && (year <= end_year);
      sample.last  = last_record;
   end

endmodule

>>> sv/mts_fifo.sv
// short queue between the front end and the accumulator back end
module mts_fifo
   import mts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  sample_type push_data,
   output logic       full,
   input  logic       pop,
   output sample_type pop_data,
   output logic       not_empty
);

   sample_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_AW:0]         cnt_ff, cnt_in;

   assign full      = cnt_ff == (FIFO_AW+1)'(FIFO_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> sv/mts_div.sv
// bit-serial q16.16 divider with sign handling and saturation
module mts_div
   import mts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WIDE_W-1:0] num,
   input  logic [WIDE_W-1:0]        den,
   output logic                     done,
   output logic signed [31:0]       quotient
);

   logic                busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in, sat_ff, sat_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [WIDE_W-1:0]   den_ff, den_in, rem_ff, rem_in;
   logic [31:0]         low_ff, low_in, q_ff, q_in;
   logic signed [31:0]  quo_ff, quo_in;
   logic [WIDE_W-1:0]   mag;
   logic [WIDE_W:0]     trial;
   logic [32:0]         res;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      mag     = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
      trial   = {rem_ff, low_ff[31]};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      quo_in  = quo_ff;
      res     = sat_ff ? 33'h1_0000_0000 : {1'b0, q_ff};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = num[WIDE_W-1];
         // quotient of 2^16 or more saturates
         sat_in  = {16'b0, mag} >= {den, 16'b0};
         den_in  = den;
         rem_in  = mag >> 16;
         low_in  = {mag[15:0], 16'b0};
         q_in    = '0;
         cnt_in  = 6'd32;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = WIDE_W'(trial - {1'b0, den_ff});
               q_in   = {q_ff[30:0], 1'b1};
            end else begin
               rem_in = WIDE_W'(trial);
               q_in   = {q_ff[30:0], 1'b0};
            end
            low_in = {low_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               quo_in = (res > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-res);
            end else begin
               quo_in = (res > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(res);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      quo_ff <= quo_in;
   end

endmodule

>>> sv/mts_back.sv
// back end: per-month accumulators and the end-of-run slope sequencer
module mts_back
   import mts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [10:0] min_samples,
   input  sample_type entry,
   input  logic       entry_valid,
   output logic       entry_pop,
   output result_type result,
   output logic       result_valid,
   input  logic       result_ready
);

   typedef enum logic [6:0] {
      S_ACC = 7'b0000001,
      S_RD  = 7'b0000010,
      S_MUL = 7'b0000100,
      S_SUB = 7'b0001000,
      S_CHK = 7'b0010000,
      S_DIV = 7'b0100000,
      S_OUT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]        cnt_ff [MONTHS];
   logic [SX_W-1:0]         sx_ff  [MONTHS];
   logic signed [SY_W-1:0]  sy_ff  [MONTHS];
   logic signed [SXY_W-1:0] sxy_ff [MONTHS];
   logic [SXX_W-1:0]        sxx_ff [MONTHS];
   logic                    ov_ff  [MONTHS];

   logic [3:0]              fin_ff, fin_in, addr;
   logic [CNT_W-1:0]        n_ff;
   logic [SX_W-1:0]         rsx_ff;
   logic signed [SY_W-1:0]  rsy_ff;
   logic signed [SXY_W-1:0] rsxy_ff;
   logic [SXX_W-1:0]        rsxx_ff;
   logic                    rov_ff, few_ff;
   logic [WIDE_W-1:0]       p1_ff, p2_ff;
   logic signed [WIDE_W-1:0] p3_ff, p4_ff, num_ff, den_ff;
   logic                    acc_en, clear_all, div_start, div_done;
   logic signed [31:0]      div_q;
   result_type              res_ff, res_in;

   assign addr         = (state_ff == S_ACC) ? entry.month : fin_ff;
   assign entry_pop    = (state_ff == S_ACC) && entry_valid;
   assign acc_en       = entry_pop && entry.take;
   assign result       = res_ff;
   assign result_valid = state_ff == S_OUT;
   assign clear_all    = (state_ff == S_OUT) && result_ready && (fin_ff == 4'(MONTHS-1));

   always_comb begin
      state_in  = state_ff;
      fin_in    = fin_ff;
      res_in    = res_ff;
      div_start = 1'b0;
      unique case (state_ff)
         S_ACC: begin
            if (entry_pop && entry.last) begin
               fin_in   = '0;
               state_in = S_RD;
            end
         end
         S_RD:  state_in = S_MUL;
         S_MUL: state_in = S_SUB;
         S_SUB: state_in = S_CHK;
         S_CHK: begin
            res_in.month_index = fin_ff;
            res_in.last_of_run = fin_ff == 4'(MONTHS-1);
            res_in.slope       = '0;
            // precedence: too few, then zero variance, then dropped
            if (few_ff) begin
               res_in.status = STAT_FEW;
               state_in      = S_OUT;
            end else if (den_ff <= 0) begin
               res_in.status = STAT_ZERO;
               state_in      = S_OUT;
            end else begin
               res_in.status = rov_ff ? STAT_DROP : STAT_OK;
               div_start     = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_in.slope = div_q;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (result_ready) begin
               if (fin_ff == 4'(MONTHS-1)) begin
                  state_in = S_ACC;
               end else begin
                  fin_in   = fin_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         default: state_in = S_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int m = 0; m < MONTHS; m++) begin
            cnt_ff[m] <= '0;
            sx_ff[m]  <= '0;
            sy_ff[m]  <= '0;
            sxy_ff[m] <= '0;
            sxx_ff[m] <= '0;
            ov_ff[m]  <= 1'b0;
         end
      end else if (acc_en) begin
         if (cnt_ff[addr] < CNT_W'(MAX_SAMPLES)) begin
            cnt_ff[addr] <= cnt_ff[addr] + 1'b1;
            sx_ff[addr]  <= sx_ff[addr] + SX_W'(entry.x);
            sy_ff[addr]  <= sy_ff[addr] + SY_W'(entry.y);
            sxy_ff[addr] <= sxy_ff[addr] + SXY_W'(entry.xy);
            sxx_ff[addr] <= sxx_ff[addr] + SXX_W'(entry.xx);
         end else begin
            ov_ff[addr] <= 1'b1;
         end
      end
      if (reset) begin
         state_ff <= S_ACC;
         fin_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
      end
      res_ff  <= res_in;
      n_ff    <= cnt_ff[addr];
      rsx_ff  <= sx_ff[addr];
      rsy_ff  <= sy_ff[addr];
      rsxy_ff <= sxy_ff[addr];
      rsxx_ff <= sxx_ff[addr];
      rov_ff  <= ov_ff[addr];
      few_ff  <= n_ff < min_samples;
      p1_ff   <= WIDE_W'(n_ff) * WIDE_W'(rsxx_ff);
      p2_ff   <= WIDE_W'(rsx_ff) * WIDE_W'(rsx_ff);
      p3_ff   <= WIDE_W'($signed({1'b0, n_ff})) * WIDE_W'(rsxy_ff);
      p4_ff   <= WIDE_W'($signed({1'b0, rsx_ff})) * WIDE_W'(rsy_ff);
      num_ff  <= p3_ff - p4_ff;
      den_ff  <= $signed(p1_ff - p2_ff);
   end

   mts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_ff),
      .den      (WIDE_W'(den_ff)),
      .done     (div_done),
      .quotient (div_q)
   );

endmodule

>>> sv/monthly_trend_slope_unit.sv
// top level: csr port, record channel, front end, queue and back end
// throughput: one record per cycle while the back end accumulates, through the 4-entry queue
// a record passes through the queue and reaches the accumulators when the back end pops it
// a last record starts a run of 12 results, each through read, multiply, subtract, check
// and, if checks pass, the 32-step serial divider; records queue behind the run, then stall
// reset: synchronous, restores register defaults and clears all accumulators
module monthly_trend_slope_unit
   import mts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mts_req_if.sink     req,
   mts_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [11:0] start_year_ff, end_year_ff;
   logic [10:0] min_samples_ff;
   logic        wr_en, fifo_full, fifo_ne, fifo_pop;
   sample_type  front_sample, fifo_out;
   result_type  res;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_START_YEAR:  csr_prdata = 32'(start_year_ff);
         REG_END_YEAR:    csr_prdata = 32'(end_year_ff);
         REG_MIN_SAMPLES: csr_prdata = 32'(min_samples_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_year_ff  <= '0;
         end_year_ff    <= 12'hFFF;
         min_samples_ff <= 11'd2;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_START_YEAR:  start_year_ff  <= csr_pwdata[11:0];
            REG_END_YEAR:    end_year_ff    <= csr_pwdata[11:0];
            REG_MIN_SAMPLES: min_samples_ff <= csr_pwdata[10:0];
            default:         ;
         endcase
      end
   end

   mts_front u_front (
      .year        (req.year),
      .month       (req.month),
      .anomaly     (req.anomaly),
      .is_missing  (req.is_missing),
      .last_record (req.last_record),
      .start_year  (start_year_ff),
      .end_year    (end_year_ff),
      .sample      (front_sample)
   );

   assign req.ready = !fifo_full;

   mts_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req.valid && !fifo_full),
      .push_data (front_sample),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (fifo_out),
      .not_empty (fifo_ne)
   );

   mts_back u_back (
      .clock        (clock),
      .reset        (reset),
      .min_samples  (min_samples_ff),
      .entry        (fifo_out),
      .entry_valid  (fifo_ne),
      .entry_pop    (fifo_pop),
      .result       (res),
      .result_valid (rsp.valid),
      .result_ready (rsp.ready)
   );

   assign rsp.month_index = res.month_index;
   assign rsp.slope       = res.slope;
   assign rsp.status      = res.status;
   assign rsp.last_of_run = res.last_of_run;

   a_last_is_final_month: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last_of_run) |-> rsp.month_index == 4'(MONTHS-1))
      else $error("last_of_run on wrong month");

   a_no_slope_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status == STAT_FEW || rsp.status == STAT_ZERO)) |-> rsp.slope == 0)
      else $error("nonzero slope with failing status");

   a_month_steps: assert property (@(posedge clock) disable iff (reset)
      ($past(rsp.valid && rsp.ready && !rsp.last_of_run) && rsp.valid) |->
         rsp.month_index == $past(rsp.month_index) + 4'd1)
      else $error("results out of month order");

endmodule
